>>> rtl/bsrw_pkg.sv
// ----------------------------------------------------------------------------
// Battery supervisor package
// Shared types and constants for the battery supervisor and reboot watchdog.
// ----------------------------------------------------------------------------
package bsrw_pkg;

   localparam int THRESH_BITS    = 12;
   localparam int TICK_BITS      = 8;
   localparam int KEY_BITS       = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [THRESH_BITS-1:0] RST_STANDBY  = 12'h4F5;
   localparam logic [THRESH_BITS-1:0] RST_ALERT    = 12'h585;
   localparam logic [THRESH_BITS-1:0] RST_CURRENT  = 12'h050;
   localparam logic [TICK_BITS-1:0]   RST_UV_TICKS = 8'd10;
   localparam logic [TICK_BITS-1:0]   RST_OC_TICKS = 8'd10;
   localparam int                     RST_WAIT     = 30;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STANDBY_THRESHOLD = 3'd0,
      CSR_ALERT_THRESHOLD   = 3'd1,
      CSR_CURRENT_THRESHOLD = 3'd2,
      CSR_UNDERVOLT_TICKS   = 3'd3,
      CSR_OVERCURRENT_TICKS = 3'd4,
      CSR_DEFAULT_WAIT      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [THRESH_BITS-1:0] standby_threshold;
      logic [THRESH_BITS-1:0] alert_threshold;
      logic [THRESH_BITS-1:0] current_threshold;
      logic [TICK_BITS-1:0]   undervolt_ticks;
      logic [TICK_BITS-1:0]   overcurrent_ticks;
   } prot_cfg_type;

   typedef struct packed {
      logic                power_on;
      logic [KEY_BITS-1:0] key_hold;
   } mon_status_type;

endpackage

>>> rtl/bsrw_csr.sv
// ----------------------------------------------------------------------------
// Battery supervisor configuration registers
// Holds the protection thresholds and the default watchdog interval.
// ----------------------------------------------------------------------------
module bsrw_csr #(
   parameter int COUNT_BITS = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [bsrw_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [bsrw_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output bsrw_pkg::prot_cfg_type                 prot_cfg,
   output logic [COUNT_BITS-1:0]                  default_wait
);
   import bsrw_pkg::*;

   prot_cfg_type            cfg_ff;
   prot_cfg_type            cfg_in;
   logic [COUNT_BITS-1:0]   wait_ff;
   logic [COUNT_BITS-1:0]   wait_in;

   assign csr_ready    = 1'b1;
   assign prot_cfg     = cfg_ff;
   assign default_wait = wait_ff;

   always_comb begin
      cfg_in  = cfg_ff;
      wait_in = wait_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_STANDBY_THRESHOLD: cfg_in.standby_threshold = csr_wdata[THRESH_BITS-1:0];
            CSR_ALERT_THRESHOLD:   cfg_in.alert_threshold   = csr_wdata[THRESH_BITS-1:0];
            CSR_CURRENT_THRESHOLD: cfg_in.current_threshold = csr_wdata[THRESH_BITS-1:0];
            CSR_UNDERVOLT_TICKS:   cfg_in.undervolt_ticks   = csr_wdata[TICK_BITS-1:0];
            CSR_OVERCURRENT_TICKS: cfg_in.overcurrent_ticks = csr_wdata[TICK_BITS-1:0];
            CSR_DEFAULT_WAIT:      wait_in                  = csr_wdata[COUNT_BITS-1:0];
            default: begin
               cfg_in  = cfg_ff;
               wait_in = wait_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.standby_threshold <= RST_STANDBY;
         cfg_ff.alert_threshold   <= RST_ALERT;
         cfg_ff.current_threshold <= RST_CURRENT;
         cfg_ff.undervolt_ticks   <= RST_UV_TICKS;
         cfg_ff.overcurrent_ticks <= RST_OC_TICKS;
         wait_ff                  <= COUNT_BITS'(RST_WAIT);
      end else begin
         cfg_ff  <= cfg_in;
         wait_ff <= wait_in;
      end
   end

endmodule

>>> rtl/bsrw_monitor.sv
// ----------------------------------------------------------------------------
// Battery supervisor sample monitor
// Halving averages, under-voltage and over-current shutdown, key hold count.
// ----------------------------------------------------------------------------
module bsrw_monitor #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             tick,
   input  logic [SAMPLE_BITS-1:0]           vbat_sample,
   input  logic [SAMPLE_BITS-1:0]           isense_sample,
   input  logic                             acc_absent,
   input  logic                             key_pressed,
   input  bsrw_pkg::prot_cfg_type           prot_cfg,
   output logic [SAMPLE_BITS-1:0]           vbat_avg_in,
   output logic [SAMPLE_BITS-1:0]           isense_avg_in,
   output bsrw_pkg::mon_status_type         status
);
   import bsrw_pkg::*;

   localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;

   logic [SAMPLE_BITS-1:0] vbat_avg_ff;
   logic [SAMPLE_BITS-1:0] isense_avg_ff;
   logic [SAMPLE_BITS:0]   vbat_sum;
   logic [SAMPLE_BITS:0]   isense_sum;
   logic [TICK_BITS-1:0]   uv_count_ff;
   logic [TICK_BITS-1:0]   uv_count_in;
   logic [TICK_BITS-1:0]   oc_count_ff;
   logic [TICK_BITS-1:0]   oc_count_in;
   logic [KEY_BITS-1:0]    key_count_ff;
   logic [KEY_BITS-1:0]    key_count_in;
   logic                   enabled_ff;
   logic                   enabled_in;
   logic [CMP_BITS-1:0]    vbat_cmp;
   logic [CMP_BITS-1:0]    isense_cmp;
   logic                   below_standby;
   logic                   below_alert;
   logic                   over_current;

   assign vbat_sum   = {1'b0, vbat_avg_ff} + {1'b0, vbat_sample};
   assign isense_sum = {1'b0, isense_avg_ff} + {1'b0, isense_sample};

   assign vbat_avg_in   = tick ? vbat_sum[SAMPLE_BITS:1] : vbat_avg_ff;
   assign isense_avg_in = tick ? isense_sum[SAMPLE_BITS:1] : isense_avg_ff;

   assign vbat_cmp      = CMP_BITS'(vbat_sum[SAMPLE_BITS:1]);
   assign isense_cmp    = CMP_BITS'(isense_sum[SAMPLE_BITS:1]);
   assign below_standby = vbat_cmp < CMP_BITS'(prot_cfg.standby_threshold);
   assign below_alert   = vbat_cmp < CMP_BITS'(prot_cfg.alert_threshold);
   assign over_current  = isense_cmp > CMP_BITS'(prot_cfg.current_threshold);

   // The checks use the averages already updated with this beat's samples.
   always_comb begin
      uv_count_in  = uv_count_ff;
      oc_count_in  = oc_count_ff;
      enabled_in   = enabled_ff;
      key_count_in = key_count_ff;
      if (tick) begin
         if (below_standby) begin
            if (uv_count_ff > prot_cfg.undervolt_ticks) begin
               enabled_in  = 1'b0;
               uv_count_in = '0;
            end else if (uv_count_ff != '1) begin
               uv_count_in = uv_count_ff + TICK_BITS'(1);
            end
            oc_count_in = '0;
         end else if (below_alert) begin
            if (acc_absent && over_current) begin
               if (oc_count_ff < prot_cfg.overcurrent_ticks) begin
                  oc_count_in = oc_count_ff + TICK_BITS'(1);
               end else begin
                  enabled_in  = 1'b0;
                  oc_count_in = '0;
               end
            end else begin
               oc_count_in = '0;
            end
            uv_count_in = '0;
         end else begin
            uv_count_in = '0;
            oc_count_in = '0;
         end

         if (!key_pressed) begin
            key_count_in = '0;
         end else if (key_count_ff != '1) begin
            key_count_in = key_count_ff + KEY_BITS'(1);
         end
      end
   end

   assign status.power_on = enabled_in;
   assign status.key_hold = key_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vbat_avg_ff   <= '0;
         isense_avg_ff <= '0;
         uv_count_ff   <= '0;
         oc_count_ff   <= '0;
         key_count_ff  <= '0;
         enabled_ff    <= 1'b1;
      end else if (step) begin
         vbat_avg_ff   <= vbat_avg_in;
         isense_avg_ff <= isense_avg_in;
         uv_count_ff   <= uv_count_in;
         oc_count_ff   <= oc_count_in;
         key_count_ff  <= key_count_in;
         enabled_ff    <= enabled_in;
      end
   end

endmodule

>>> rtl/bsrw_watchdog.sv
// ----------------------------------------------------------------------------
// Battery supervisor reboot watchdog
// Start delay and watchdog interval counters, fed by feed beats.
// ----------------------------------------------------------------------------
module bsrw_watchdog #(
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  feed,
   input  logic                  acc_absent,
   input  logic                  power_on,
   input  logic [COUNT_BITS-1:0] start_wait,
   input  logic [COUNT_BITS-1:0] between_wait,
   input  logic [COUNT_BITS-1:0] default_wait,
   output logic                  reboot,
   output logic [COUNT_BITS-1:0] start_count_in,
   output logic [COUNT_BITS-1:0] between_count_in,
   output logic [COUNT_BITS-1:0] between_limit_in
);
   import bsrw_pkg::*;

   logic [COUNT_BITS-1:0] start_count_ff;
   logic [COUNT_BITS-1:0] between_count_ff;
   logic [COUNT_BITS-1:0] start_limit_ff;
   logic [COUNT_BITS-1:0] start_limit_in;
   logic [COUNT_BITS-1:0] between_limit_ff;
   logic [COUNT_BITS-1:0] advanced;

   always_comb begin
      start_count_in   = start_count_ff;
      between_count_in = between_count_ff;
      start_limit_in   = start_limit_ff;
      between_limit_in = between_limit_ff;
      advanced         = between_count_ff;
      reboot           = 1'b0;
      if (feed) begin
         // The start delay is treated as already served after a feed.
         start_limit_in   = (start_wait == '0) ? default_wait : start_wait;
         start_count_in   = start_limit_in;
         between_limit_in = (between_wait == '0) ? default_wait : between_wait;
         between_count_in = '0;
      end else if (!acc_absent && power_on) begin
         if (start_count_ff < start_limit_ff) begin
            start_count_in = start_count_ff + COUNT_BITS'(1);
         end else if (between_count_ff != '1) begin
            advanced         = between_count_ff + COUNT_BITS'(1);
            between_count_in = advanced;
         end
         if (between_count_in > between_limit_ff) begin
            reboot           = 1'b1;
            start_count_in   = '0;
            between_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_count_ff   <= '0;
         between_count_ff <= '0;
         start_limit_ff   <= COUNT_BITS'(RST_WAIT);
         between_limit_ff <= COUNT_BITS'(RST_WAIT);
      end else if (step) begin
         start_count_ff   <= start_count_in;
         between_count_ff <= between_count_in;
         start_limit_ff   <= start_limit_in;
         between_limit_ff <= between_limit_in;
      end
   end

endmodule

>>> rtl/battery_supervisor_with_reboot_watchdog.sv
// ----------------------------------------------------------------------------
// Battery supervisor with reboot watchdog
// Top level: input stage, monitor, watchdog and result register.
// ----------------------------------------------------------------------------
// Each beat on the req_ channel is either a one-second tick (req_mode 0)
// carrying battery and current samples plus the accessory and key pins, or a
// watchdog feed (req_mode 1) carrying new start and watchdog intervals.
// Every beat produces exactly one beat on the rsp_ channel with the power
// state, the reboot flag and the updated counters and averages.
// A beat is captured in an input register; once the result register is free
// or drains, the monitor and watchdog logic compute the new state and load
// the result register. While the receiver does not stall, one beat is taken
// every cycle: the throughput is set by the single state update per cycle.
// When the receiver stalls, the result register holds its beat and the
// input register fills; req_ready then drops until rsp_ready returns, and
// no beat is lost or repeated.
// The csr_ channel is always ready and writes the thresholds and the default
// interval; write it only while no beat is in flight, which goes unchecked.
// Synchronous reset empties both registers, turns power on, clears the
// averages and counters and sets both intervals to thirty ticks.
// ----------------------------------------------------------------------------
module battery_supervisor_with_reboot_watchdog #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [SAMPLE_BITS-1:0]              req_vbat_sample,
   input  logic [SAMPLE_BITS-1:0]              req_isense_sample,
   input  logic                                req_acc_absent,
   input  logic                                req_key_pressed,
   input  logic [COUNT_BITS-1:0]               req_start_wait,
   input  logic [COUNT_BITS-1:0]               req_between_wait,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_power_on,
   output logic                                rsp_reboot_request,
   output logic [COUNT_BITS-1:0]               rsp_start_count,
   output logic [COUNT_BITS-1:0]               rsp_between_count,
   output logic [COUNT_BITS-1:0]               rsp_between_limit,
   output logic [SAMPLE_BITS-1:0]              rsp_vbat_average,
   output logic [SAMPLE_BITS-1:0]              rsp_isense_average,
   output logic [bsrw_pkg::KEY_BITS-1:0]       rsp_key_hold_time,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bsrw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bsrw_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import bsrw_pkg::*;

   prot_cfg_type            prot_cfg;
   logic [COUNT_BITS-1:0]   default_wait;
   mon_status_type          status;

   logic                    in_valid_ff;
   logic                    in_mode_ff;
   logic [SAMPLE_BITS-1:0]  in_vbat_ff;
   logic [SAMPLE_BITS-1:0]  in_isense_ff;
   logic                    in_acc_absent_ff;
   logic                    in_key_ff;
   logic [COUNT_BITS-1:0]   in_start_wait_ff;
   logic [COUNT_BITS-1:0]   in_between_wait_ff;
   logic                    advance;
   logic                    req_fire;

   logic [SAMPLE_BITS-1:0]  vbat_avg_in;
   logic [SAMPLE_BITS-1:0]  isense_avg_in;
   logic                    reboot;
   logic [COUNT_BITS-1:0]   start_count_in;
   logic [COUNT_BITS-1:0]   between_count_in;
   logic [COUNT_BITS-1:0]   between_limit_in;

   logic                    out_valid_ff;
   logic                    out_power_on_ff;
   logic                    out_reboot_ff;
   logic [COUNT_BITS-1:0]   out_start_count_ff;
   logic [COUNT_BITS-1:0]   out_between_count_ff;
   logic [COUNT_BITS-1:0]   out_between_limit_ff;
   logic [SAMPLE_BITS-1:0]  out_vbat_avg_ff;
   logic [SAMPLE_BITS-1:0]  out_isense_avg_ff;
   logic [KEY_BITS-1:0]     out_key_hold_ff;

   // The held beat moves on whenever the result register is free or drains.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   bsrw_csr #(
      .COUNT_BITS (COUNT_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .prot_cfg     (prot_cfg),
      .default_wait (default_wait)
   );

   bsrw_monitor #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_monitor (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .tick          (!in_mode_ff),
      .vbat_sample   (in_vbat_ff),
      .isense_sample (in_isense_ff),
      .acc_absent    (in_acc_absent_ff),
      .key_pressed   (in_key_ff),
      .prot_cfg      (prot_cfg),
      .vbat_avg_in   (vbat_avg_in),
      .isense_avg_in (isense_avg_in),
      .status        (status)
   );

   bsrw_watchdog #(
      .COUNT_BITS (COUNT_BITS)
   ) u_watchdog (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .feed             (in_mode_ff),
      .acc_absent       (in_acc_absent_ff),
      .power_on         (status.power_on),
      .start_wait       (in_start_wait_ff),
      .between_wait     (in_between_wait_ff),
      .default_wait     (default_wait),
      .reboot           (reboot),
      .start_count_in   (start_count_in),
      .between_count_in (between_count_in),
      .between_limit_in (between_limit_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_mode_ff         <= req_mode;
         in_vbat_ff         <= req_vbat_sample;
         in_isense_ff       <= req_isense_sample;
         in_acc_absent_ff   <= req_acc_absent;
         in_key_ff          <= req_key_pressed;
         in_start_wait_ff   <= req_start_wait;
         in_between_wait_ff <= req_between_wait;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_power_on_ff      <= status.power_on;
         out_reboot_ff        <= reboot;
         out_start_count_ff   <= start_count_in;
         out_between_count_ff <= between_count_in;
         out_between_limit_ff <= between_limit_in;
         out_vbat_avg_ff      <= vbat_avg_in;
         out_isense_avg_ff    <= isense_avg_in;
         out_key_hold_ff      <= status.key_hold;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_power_on       = out_power_on_ff;
   assign rsp_reboot_request = out_reboot_ff;
   assign rsp_start_count    = out_start_count_ff;
   assign rsp_between_count  = out_between_count_ff;
   assign rsp_between_limit  = out_between_limit_ff;
   assign rsp_vbat_average   = out_vbat_avg_ff;
   assign rsp_isense_average = out_isense_avg_ff;
   assign rsp_key_hold_time  = out_key_hold_ff;

endmodule

>>> rtl/bsrw_checker.sv
// ----------------------------------------------------------------------------
// Battery supervisor checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module bsrw_checker #(
   parameter int SAMPLE_BITS = 12,
   parameter int COUNT_BITS  = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_power_on,
   input  logic                   rsp_reboot_request,
   input  logic [COUNT_BITS-1:0]  rsp_start_count,
   input  logic [COUNT_BITS-1:0]  rsp_between_count,
   input  logic [SAMPLE_BITS-1:0] rsp_vbat_average
);

   // A stalled beat stays offered and keeps its counters and battery average.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_count)
         && $stable(rsp_between_count) && $stable(rsp_vbat_average))
      else $error("stalled result beat changed");

   // Once power has been seen off, it stays off until reset.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_power_on |=> !rsp_power_on)
      else $error("power came back on without reset");

   // A reboot clears both watchdog counters in the same beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reboot_request |-> rsp_start_count == '0
         && rsp_between_count == '0)
      else $error("reboot beat with counters not cleared");

   // The watchdog only runs, and so only fires, while power is on.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reboot_request |-> rsp_power_on)
      else $error("reboot requested with power off");

   // Nothing is offered straight after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind battery_supervisor_with_reboot_watchdog bsrw_checker #(
   .SAMPLE_BITS (SAMPLE_BITS),
   .COUNT_BITS  (COUNT_BITS)
) u_bsrw_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_power_on       (rsp_power_on),
   .rsp_reboot_request (rsp_reboot_request),
   .rsp_start_count    (rsp_start_count),
   .rsp_between_count  (rsp_between_count),
   .rsp_vbat_average   (rsp_vbat_average)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery supervisor with reboot watchdog testbench
// Drives tick and feed beats through the request channel, predicts every
// result beat with a cycle-free model of the averaging, protection, key and
// watchdog logic, and compares each result field by field. A short directed
// table comes first, then random phases under several register settings and
// several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
   import bsrw_pkg::*;

   localparam logic MODE_TICK   = 1'b0;
   localparam logic MODE_FEED   = 1'b1;
   localparam int   STALL_LIMIT = 2000;
   localparam int   DRAIN_WAIT  = 8;

   typedef struct packed {
      logic        mode;
      logic [11:0] vbat;
      logic [11:0] isense;
      logic        acc_absent;
      logic        key;
      logic [31:0] start_wait;
      logic [31:0] between_wait;
   } sup_item_type;

   typedef struct packed {
      logic        power_on;
      logic        reboot;
      logic [31:0] start_count;
      logic [31:0] between_count;
      logic [31:0] between_limit;
      logic [11:0] vbat_average;
      logic [11:0] isense_average;
      logic [7:0]  key_hold;
   } sup_result_type;

   typedef struct packed {
      sup_item_type   item;
      logic           typed;
      sup_result_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_mode;
   logic [11:0] req_vbat_sample;
   logic [11:0] req_isense_sample;
   logic        req_acc_absent;
   logic        req_key_pressed;
   logic [31:0] req_start_wait;
   logic [31:0] req_between_wait;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_power_on;
   logic        rsp_reboot_request;
   logic [31:0] rsp_start_count;
   logic [31:0] rsp_between_count;
   logic [31:0] rsp_between_limit;
   logic [11:0] rsp_vbat_average;
   logic [11:0] rsp_isense_average;
   logic [7:0]  rsp_key_hold_time;
   logic        csr_valid;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // Predictor state and its copy of the registers
   prot_cfg_type prot_cfg;
   logic [31:0]  fallback_wait;
   logic [11:0]  vbat_mean;
   logic [11:0]  isense_mean;
   logic [7:0]   undervolt_run;
   logic [7:0]   overcurrent_run;
   logic [7:0]   key_run;
   logic         supply_on;
   logic [31:0]  start_cnt;
   logic [31:0]  between_cnt;
   logic [31:0]  start_lim;
   logic [31:0]  between_lim;

   sup_result_type pending_results[$];
   dir_row_type    directed_rows[$];
   int          errors;
   int          results_checked;
   int          reboots_seen;
   int          beats_sent;
   int          idle_cycles;
   int          send_idle_pct;
   int          stall_pct;
   logic        acc_level;
   logic        key_level;

   battery_supervisor_with_reboot_watchdog dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_vbat_sample    (req_vbat_sample),
      .req_isense_sample  (req_isense_sample),
      .req_acc_absent     (req_acc_absent),
      .req_key_pressed    (req_key_pressed),
      .req_start_wait     (req_start_wait),
      .req_between_wait   (req_between_wait),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_power_on       (rsp_power_on),
      .rsp_reboot_request (rsp_reboot_request),
      .rsp_start_count    (rsp_start_count),
      .rsp_between_count  (rsp_between_count),
      .rsp_between_limit  (rsp_between_limit),
      .rsp_vbat_average   (rsp_vbat_average),
      .rsp_isense_average (rsp_isense_average),
      .rsp_key_hold_time  (rsp_key_hold_time),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One beat of the supervisor: returns the result and advances the state.
   function automatic sup_result_type supervise(input sup_item_type it);
      logic [12:0] vsum;
      logic [12:0] isum;
      logic        reboot;
      sup_result_type res;
      reboot = 1'b0;
      if (it.mode == MODE_FEED) begin
         start_lim   = (it.start_wait == 32'd0) ? fallback_wait : it.start_wait;
         start_cnt   = start_lim;
         between_lim = (it.between_wait == 32'd0) ? fallback_wait : it.between_wait;
         between_cnt = 32'd0;
      end else begin
         vsum        = {1'b0, vbat_mean} + {1'b0, it.vbat};
         isum        = {1'b0, isense_mean} + {1'b0, it.isense};
         vbat_mean   = vsum[12:1];
         isense_mean = isum[12:1];

         if (vbat_mean < prot_cfg.standby_threshold) begin
            if (undervolt_run > prot_cfg.undervolt_ticks) begin
               supply_on     = 1'b0;
               undervolt_run = 8'd0;
            end else if (undervolt_run != 8'hFF) begin
               undervolt_run = undervolt_run + 8'd1;
            end
            overcurrent_run = 8'd0;
         end else if (vbat_mean < prot_cfg.alert_threshold) begin
            // Over-current only matters while the accessory line is absent.
            if (it.acc_absent && isense_mean > prot_cfg.current_threshold) begin
               if (overcurrent_run < prot_cfg.overcurrent_ticks) begin
                  overcurrent_run = overcurrent_run + 8'd1;
               end else begin
                  supply_on       = 1'b0;
                  overcurrent_run = 8'd0;
               end
            end else begin
               overcurrent_run = 8'd0;
            end
            undervolt_run = 8'd0;
         end else begin
            overcurrent_run = 8'd0;
            undervolt_run   = 8'd0;
         end

         if (!it.key)
            key_run = 8'd0;
         else if (key_run != 8'hFF)
            key_run = key_run + 8'd1;

         if (!it.acc_absent && supply_on) begin
            if (start_cnt < start_lim)
               start_cnt = start_cnt + 32'd1;
            else if (between_cnt != 32'hFFFF_FFFF)
               between_cnt = between_cnt + 32'd1;
            if (between_cnt > between_lim) begin
               reboot      = 1'b1;
               start_cnt   = 32'd0;
               between_cnt = 32'd0;
            end
         end
      end
      res.power_on       = supply_on;
      res.reboot         = reboot;
      res.start_count    = start_cnt;
      res.between_count  = between_cnt;
      res.between_limit  = between_lim;
      res.vbat_average   = vbat_mean;
      res.isense_average = isense_mean;
      res.key_hold       = key_run;
      return res;
   endfunction

   function automatic logic [31:0] pick_wait();
      int roll;
      roll = $urandom_range(99);
      if (roll < 15)
         return 32'd0;
      else if (roll < 85)
         return $urandom_range(6, 1);
      else
         return $urandom();
   endfunction

   // Mostly plausible ticks and short feeds so that the watchdog keeps
   // expiring; a few beats are pure noise.
   function automatic sup_item_type rand_item(input logic key_held);
      sup_item_type it;
      if ($urandom_range(99) < 5) begin
         it.mode         = 1'($urandom_range(1, 0));
         it.vbat         = 12'($urandom_range(4095, 0));
         it.isense       = 12'($urandom_range(4095, 0));
         it.acc_absent   = 1'($urandom_range(1, 0));
         it.key          = key_held | 1'($urandom_range(1, 0));
         it.start_wait   = $urandom();
         it.between_wait = $urandom();
      end else begin
         if (!acc_level && $urandom_range(99) < 5)
            acc_level = 1'b1;
         else if (acc_level && $urandom_range(99) < 25)
            acc_level = 1'b0;
         if ($urandom_range(99) < 15)
            key_level = !key_level;
         it.mode         = ($urandom_range(99) < 12) ? MODE_FEED : MODE_TICK;
         it.vbat         = ($urandom_range(99) < 70) ? 12'($urandom_range(4095, 1500))
                                                     : 12'($urandom_range(4095, 0));
         it.isense       = 12'($urandom_range(4095, 0));
         it.acc_absent   = acc_level;
         it.key          = key_held | key_level;
         it.start_wait   = pick_wait();
         it.between_wait = pick_wait();
      end
      return it;
   endfunction

   function automatic void add_row(input logic mode, input logic [11:0] vbat,
                                   input logic [11:0] isense, input logic acc,
                                   input logic key, input logic [31:0] sw,
                                   input logic [31:0] bw, input logic typed,
                                   input sup_result_type want);
      dir_row_type row;
      row.item  = {mode, vbat, isense, acc, key, sw, bw};
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < 40)
         $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                  results_checked, what, got, want);
      errors++;
   endtask

   // Called at a falling edge; returns at the falling edge after the beat.
   task automatic send_beat(input sup_item_type it, input logic typed,
                            input sup_result_type typed_want);
      sup_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_mode          = it.mode;
      req_vbat_sample   = it.vbat;
      req_isense_sample = it.isense;
      req_acc_absent    = it.acc_absent;
      req_key_pressed   = it.key;
      req_start_wait    = it.start_wait;
      req_between_wait  = it.between_wait;
      req_valid         = 1'b1;
      do @(posedge clock); while (!req_ready);
      predicted = supervise(it);
      pending_results.push_back(typed ? typed_want : predicted);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_STANDBY_THRESHOLD: prot_cfg.standby_threshold = data[11:0];
         CSR_ALERT_THRESHOLD:   prot_cfg.alert_threshold   = data[11:0];
         CSR_CURRENT_THRESHOLD: prot_cfg.current_threshold = data[11:0];
         CSR_UNDERVOLT_TICKS:   prot_cfg.undervolt_ticks   = data[7:0];
         CSR_OVERCURRENT_TICKS: prot_cfg.overcurrent_ticks = data[7:0];
         CSR_DEFAULT_WAIT:      fallback_wait              = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_settings(input logic [11:0] standby, input logic [11:0] alert,
                                 input logic [11:0] current, input logic [7:0] uv,
                                 input logic [7:0] oc, input logic [31:0] dflt);
      drain();
      write_csr(CSR_STANDBY_THRESHOLD, {20'd0, standby});
      write_csr(CSR_ALERT_THRESHOLD, {20'd0, alert});
      write_csr(CSR_CURRENT_THRESHOLD, {20'd0, current});
      write_csr(CSR_UNDERVOLT_TICKS, {24'd0, uv});
      write_csr(CSR_OVERCURRENT_TICKS, {24'd0, oc});
      write_csr(CSR_DEFAULT_WAIT, dflt);
      csr_valid = 1'b0;
   endtask

   task automatic run_random(input int count, input logic key_held);
      for (int n = 0; n < count; n++)
         send_beat(rand_item(key_held), 1'b0, '0);
   endtask

   always @(negedge clock) begin
      if (!reset)
         rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   // Result checking and the no-progress watchdog
   always @(posedge clock) begin
      sup_result_type want;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result beat with nothing pending", 32'd0, 32'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_power_on !== want.power_on)
                  report_mismatch("power_on", 32'(rsp_power_on), 32'(want.power_on));
               if (rsp_reboot_request !== want.reboot)
                  report_mismatch("reboot_request", 32'(rsp_reboot_request),
                                  32'(want.reboot));
               if (rsp_start_count !== want.start_count)
                  report_mismatch("start_count", rsp_start_count, want.start_count);
               if (rsp_between_count !== want.between_count)
                  report_mismatch("between_count", rsp_between_count, want.between_count);
               if (rsp_between_limit !== want.between_limit)
                  report_mismatch("between_limit", rsp_between_limit, want.between_limit);
               if (rsp_vbat_average !== want.vbat_average)
                  report_mismatch("vbat_average", 32'(rsp_vbat_average),
                                  32'(want.vbat_average));
               if (rsp_isense_average !== want.isense_average)
                  report_mismatch("isense_average", 32'(rsp_isense_average),
                                  32'(want.isense_average));
               if (rsp_key_hold_time !== want.key_hold)
                  report_mismatch("key_hold_time", 32'(rsp_key_hold_time),
                                  32'(want.key_hold));
            end
            if (rsp_reboot_request === 1'b1)
               reboots_seen++;
            results_checked++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
               $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

   initial begin
      sup_item_type it;
      logic      brown_out;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_mode          = MODE_TICK;
      req_vbat_sample   = '0;
      req_isense_sample = '0;
      req_acc_absent    = 1'b0;
      req_key_pressed   = 1'b0;
      req_start_wait    = '0;
      req_between_wait  = '0;
      rsp_ready         = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = CSR_STANDBY_THRESHOLD;
      csr_wdata         = '0;
      errors            = 0;
      results_checked   = 0;
      reboots_seen      = 0;
      beats_sent        = 0;
      idle_cycles       = 0;
      send_idle_pct     = 0;
      stall_pct         = 0;
      acc_level         = 1'b0;
      key_level         = 1'b0;

      prot_cfg        = {RST_STANDBY, RST_ALERT, RST_CURRENT, RST_UV_TICKS, RST_OC_TICKS};
      fallback_wait   = RST_WAIT;
      vbat_mean       = '0;
      isense_mean     = '0;
      undervolt_run   = '0;
      overcurrent_run = '0;
      key_run         = '0;
      supply_on       = 1'b1;
      start_cnt       = '0;
      between_cnt     = '0;
      start_lim       = RST_WAIT;
      between_lim     = RST_WAIT;

      // Directed table under the reset register values. Typed rows carry a
      // result that follows at a glance; the rest go through the predictor.
      add_row(MODE_TICK, 12'd0, 12'd0, 1'b1, 1'b0, 32'd0, 32'd0, 1'b1,
              {1'b1, 1'b0, 32'd0, 32'd0, 32'd30, 12'd0, 12'd0, 8'd0});
      add_row(MODE_TICK, 12'hFFF, 12'hFFF, 1'b0, 1'b1, 32'd0, 32'd0, 1'b1,
              {1'b1, 1'b0, 32'd1, 32'd0, 32'd30, 12'd2047, 12'd2047, 8'd1});
      // A zero feed falls back to the default interval for both limits.
      add_row(MODE_FEED, 12'hFFF, 12'hFFF, 1'b1, 1'b0, 32'd0, 32'd0, 1'b1,
              {1'b1, 1'b0, 32'd30, 32'd0, 32'd30, 12'd2047, 12'd2047, 8'd1});
      // Largest intervals: the watchdog can then never expire.
      add_row(MODE_FEED, 12'd0, 12'd0, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              {1'b1, 1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 12'd2047, 12'd2047, 8'd1});
      add_row(MODE_TICK, 12'hFFF, 12'd0, 1'b0, 1'b1, 32'd0, 32'd0, 1'b0, '0);
      // Shortest intervals, then ticks until the watchdog expires twice.
      add_row(MODE_FEED, 12'd0, 12'd0, 1'b0, 1'b0, 32'd1, 32'd1, 1'b0, '0);
      add_row(MODE_TICK, 12'hFFF, 12'd0, 1'b0, 1'b1, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'hFFF, 12'd0, 1'b0, 1'b1, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'hFFF, 12'd0, 1'b0, 1'b1, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'hFFF, 12'd0, 1'b1, 1'b1, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'hFFF, 12'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'hFFF, 12'd0, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
      // Brief under-voltage, then the alert band with the accessory absent.
      add_row(MODE_TICK, 12'd0, 12'hFFF, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'd0, 12'hFFF, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'd1700, 12'hFFF, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'd1340, 12'hFFF, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'd1340, 12'hFFF, 1'b1, 1'b0, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'd1340, 12'hFFF, 1'b0, 1'b0, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_TICK, 12'hFFF, 12'hFFF, 1'b0, 1'b1, 32'd0, 32'd0, 1'b0, '0);
      add_row(MODE_FEED, 12'hAAA, 12'h555, 1'b1, 1'b1, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
              1'b0, '0);
      add_row(MODE_FEED, 12'd0, 12'd0, 1'b0, 1'b0, 32'd2, 32'd0, 1'b0, '0);

      repeat (6) @(negedge clock);
      reset = 1'b0;

      for (int n = 0; n < directed_rows.size(); n++)
         send_beat(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);

      // Lowest standby and highest alert and current thresholds, zero default
      // wait; the key stays held long enough to saturate the hold time.
      write_settings(12'd0, 12'hFFF, 12'hFFF, 8'd0, 8'hFF, 32'd0);
      run_random(320, 1'b1);

      write_settings(12'hFFF, 12'd0, 12'd0, 8'hFF, 8'd0, $urandom_range(8, 1));
      send_idle_pct = 58;
      run_random(20, 1'b0);

      write_settings(12'($urandom_range(4095, 0)), 12'($urandom_range(4095, 0)),
                     12'($urandom_range(4095, 0)), 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send_idle_pct = 0;
      stall_pct     = 58;
      run_random(20, 1'b0);

      write_settings(RST_STANDBY, RST_ALERT, RST_CURRENT, RST_UV_TICKS, RST_OC_TICKS,
                     RST_WAIT);
      send_idle_pct = 37;
      stall_pct     = 37;
      run_random(15, 1'b0);

      // Sustained fault so that the supply latches off, either from a
      // brown-out or from over-current with the accessory line absent.
      brown_out = 1'($urandom_range(1, 0));
      for (int n = 0; n < 24; n++) begin
         it              = '0;
         it.mode         = MODE_TICK;
         it.vbat         = brown_out ? 12'($urandom_range(200, 0)) : 12'd1340;
         it.isense       = 12'($urandom_range(4095, 3000));
         it.acc_absent   = brown_out ? 1'($urandom_range(1, 0)) : 1'b1;
         it.key          = 1'($urandom_range(1, 0));
         send_beat(it, 1'b0, '0);
      end
      run_random(5, 1'b0);

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", pending_results.size(), 32'd0);

      $display("Covered %0d beats (%0d from the directed table) over five register settings",
               beats_sent, directed_rows.size());
      $display("and four idling patterns; %0d results checked, %0d watchdog reboots, %s.",
               results_checked, reboots_seen,
               brown_out ? "brown-out shutdown" : "over-current shutdown");
      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
